@@ rtl/pfid_pkg.sv @@
package pfid_pkg;

    // Operand and result width of the payload.
    localparam int WIDTH     = 32;
    // Residues, the modulus and the Euclidean remainders.
    localparam int MOD_W     = 31;
    // Signed Bezout coefficient; its magnitude never exceeds the modulus.
    localparam int COEF_W    = MOD_W + 3;
    localparam int PROD_W    = 2 * MOD_W;
    localparam int SRC_W     = (WIDTH > PROD_W) ? WIDTH : PROD_W;
    localparam int SCNT_W    = $clog2(SRC_W + 1);
    localparam int SHIFT_W   = $clog2(MOD_W);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MOD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC = 1'd1;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'h7FFF_FFFF;

    localparam logic [1:0] CMD_REDUCE  = 2'd0;
    localparam logic [1:0] CMD_INVERSE = 2'd1;
    localparam logic [1:0] CMD_DIVIDE  = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [WIDTH-1:0] operand;
        logic signed [WIDTH-1:0] divisor;
    } t_in_item;

    typedef struct packed {
        logic signed [WIDTH-1:0] value;
        logic                    status;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [SRC_W-1:0]  src;
        logic [SCNT_W-1:0] nbits;
    } t_smod_req;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] rem;
    } t_smod_rsp;

    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] a;
    } t_eu_req;

    typedef struct packed {
        logic             done;
        logic             ok;
        logic [MOD_W-1:0] inv;
    } t_eu_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_OP,
        ST_RED_DIV,
        ST_INV,
        ST_MUL,
        ST_PROD_LOAD,
        ST_RED_PROD,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        EU_IDLE,
        EU_CHECK,
        EU_ALIGN,
        EU_SUB,
        EU_FIN
    } t_eu_state;

endpackage

@@ rtl/pfid_serial_mod.sv @@
module pfid_serial_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfid_pkg::t_smod_req           i_req,
    input  logic [pfid_pkg::MOD_W-1:0]    i_p,
    output pfid_pkg::t_smod_rsp           o_rsp
);

    logic                            r_busy, n_busy;
    logic [pfid_pkg::SCNT_W-1:0]     r_cnt, n_cnt;
    logic [pfid_pkg::SRC_W-1:0]      r_src, n_src;
    logic [pfid_pkg::MOD_W-1:0]      r_acc, n_acc;
    logic [pfid_pkg::MOD_W:0]        acc2;

    // One source bit enters per cycle; the accumulator stays below p, so one
    // conditional subtraction keeps it reduced.
    always_comb begin
        acc2   = {r_acc, r_src[pfid_pkg::SRC_W-1]};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_src  = r_src;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.nbits;
            n_src  = i_req.src;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - pfid_pkg::SCNT_W'(1);
                n_src = r_src << 1;
                if (acc2 >= {1'b0, i_p}) begin
                    n_acc = pfid_pkg::MOD_W'(acc2 - {1'b0, i_p});
                end else begin
                    n_acc = acc2[pfid_pkg::MOD_W-1:0];
                end
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_src <= n_src;
        r_acc <= n_acc;
    end

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.rem  = r_acc;

endmodule

@@ rtl/pfid_euclid.sv @@
module pfid_euclid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfid_pkg::t_eu_req             i_req,
    input  logic [pfid_pkg::MOD_W-1:0]    i_p,
    output pfid_pkg::t_eu_rsp             o_rsp
);

    pfid_pkg::t_eu_state                 r_state, n_state;
    logic [pfid_pkg::MOD_W-1:0]          r_r, n_r;
    logic [pfid_pkg::MOD_W-1:0]          r_d, n_d;
    logic signed [pfid_pkg::COEF_W-1:0]  r_t, n_t;
    logic signed [pfid_pkg::COEF_W-1:0]  r_dt, n_dt;
    logic [pfid_pkg::SHIFT_W-1:0]        r_k, n_k;

    logic                                can_shift;
    logic                                can_sub;
    logic [pfid_pkg::MOD_W-1:0]          rem;
    logic signed [pfid_pkg::COEF_W-1:0]  t_sub;
    logic signed [pfid_pkg::COEF_W-1:0]  p_ext;
    logic signed [pfid_pkg::COEF_W-1:0]  t_plus_p;
    logic signed [pfid_pkg::COEF_W-1:0]  t_minus_p;

    // The divisor d and its coefficient dt are shifted up until 2d exceeds r,
    // then walked back down one bit a cycle, subtracting where they fit. The
    // quotient is never formed; t has q * dt subtracted from it bit by bit.
    assign can_shift = ({r_d, 1'b0} <= {1'b0, r_r});
    assign can_sub   = (r_d <= r_r);
    assign rem       = can_sub ? (r_r - r_d) : r_r;
    assign t_sub     = can_sub ? (r_t - r_dt) : r_t;
    assign p_ext     = $signed({{(pfid_pkg::COEF_W-pfid_pkg::MOD_W){1'b0}}, i_p});
    assign t_plus_p  = r_t + p_ext;
    assign t_minus_p = r_t - p_ext;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfid_pkg::EU_IDLE: begin
                if (i_req.start) begin
                    n_state = pfid_pkg::EU_CHECK;
                end
            end
            pfid_pkg::EU_CHECK: begin
                n_state = (r_d == '0) ? pfid_pkg::EU_FIN : pfid_pkg::EU_ALIGN;
            end
            pfid_pkg::EU_ALIGN: begin
                if (!can_shift) begin
                    n_state = pfid_pkg::EU_SUB;
                end
            end
            pfid_pkg::EU_SUB: begin
                if (r_k == '0) begin
                    n_state = pfid_pkg::EU_CHECK;
                end
            end
            pfid_pkg::EU_FIN: begin
                n_state = pfid_pkg::EU_IDLE;
            end
            default: begin
                n_state = pfid_pkg::EU_IDLE;
            end
        endcase
    end

    always_comb begin
        n_r  = r_r;
        n_d  = r_d;
        n_t  = r_t;
        n_dt = r_dt;
        n_k  = r_k;
        o_rsp.done = 1'b0;
        o_rsp.ok   = 1'b0;
        o_rsp.inv  = '0;
        case (r_state)
            pfid_pkg::EU_IDLE: begin
                if (i_req.start) begin
                    n_r  = i_p;
                    n_d  = i_req.a;
                    n_t  = '0;
                    n_dt = {{(pfid_pkg::COEF_W-1){1'b0}}, 1'b1};
                    n_k  = '0;
                end
            end
            pfid_pkg::EU_ALIGN: begin
                if (can_shift) begin
                    n_d  = r_d << 1;
                    n_dt = r_dt <<< 1;
                    n_k  = r_k + pfid_pkg::SHIFT_W'(1);
                end
            end
            pfid_pkg::EU_SUB: begin
                if (r_k == '0) begin
                    // Quotient step finished: rotate the remainder pairs.
                    n_r  = r_d;
                    n_t  = r_dt;
                    n_d  = rem;
                    n_dt = t_sub;
                end else begin
                    n_r  = rem;
                    n_t  = t_sub;
                    n_d  = r_d >> 1;
                    n_dt = r_dt >>> 1;
                    n_k  = r_k - pfid_pkg::SHIFT_W'(1);
                end
            end
            pfid_pkg::EU_FIN: begin
                o_rsp.done = 1'b1;
                o_rsp.ok   = (r_r == pfid_pkg::MOD_W'(1));
                if (r_r == pfid_pkg::MOD_W'(1)) begin
                    if (r_t < 0) begin
                        o_rsp.inv = t_plus_p[pfid_pkg::MOD_W-1:0];
                    end else if (r_t >= p_ext) begin
                        o_rsp.inv = t_minus_p[pfid_pkg::MOD_W-1:0];
                    end else begin
                        o_rsp.inv = r_t[pfid_pkg::MOD_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfid_pkg::EU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r  <= n_r;
        r_d  <= n_d;
        r_t  <= n_t;
        r_dt <= n_dt;
        r_k  <= n_k;
    end

endmodule

@@ rtl/prime_field_inverse_divide_core.sv @@
// Steps: reduce returns the operand reduced mod p; inverse adds the Euclidean quotient steps,
// each an alignment of the divisor and a walk back down over the quotient bits; divide adds
// a 32-bit divisor reduction and a 62-bit product reduction.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) clears all control state, sets the modulus to
// 2147483647 and selects the range 0..p-1.
module prime_field_inverse_divide_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pfid_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pfid_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pfid_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pfid_pkg::t_out_item                o_out_item
);

    pfid_pkg::t_state                r_state, n_state;
    logic [pfid_pkg::MOD_W-1:0]      r_modulus;
    logic                            r_sym;
    pfid_pkg::t_in_item              r_item, n_item;
    logic [pfid_pkg::MOD_W-1:0]      r_a, n_a;
    logic [pfid_pkg::MOD_W-1:0]      r_inv, n_inv;
    logic [pfid_pkg::PROD_W-1:0]     r_prod, n_prod;
    logic [pfid_pkg::MOD_W-1:0]      r_res, n_res;
    logic                            r_status, n_status;
    pfid_pkg::t_out_item             r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    logic [pfid_pkg::MOD_W-1:0]      p_eff;
    logic                            in_acc;
    logic                            out_free;
    logic                            fix_neg;
    logic [pfid_pkg::MOD_W-1:0]      fixed;
    pfid_pkg::t_smod_req             smod_req;
    pfid_pkg::t_smod_rsp             smod_rsp;
    pfid_pkg::t_eu_req               eu_req;
    pfid_pkg::t_eu_rsp               eu_rsp;

    function automatic logic [pfid_pkg::WIDTH-1:0] f_mag(
        input logic [pfid_pkg::WIDTH-1:0] x
    );
        f_mag = x[pfid_pkg::WIDTH-1] ? (~x + pfid_pkg::WIDTH'(1)) : x;
    endfunction

    function automatic logic [pfid_pkg::WIDTH-1:0] f_present(
        input logic [pfid_pkg::MOD_W-1:0] n,
        input logic [pfid_pkg::MOD_W-1:0] p,
        input logic                       sym
    );
        logic [pfid_pkg::MOD_W-1:0]     half;
        logic signed [pfid_pkg::MOD_W+1:0] v;
        half = p >> 1;
        v    = $signed({2'b00, n});
        if (sym && (n > half)) begin
            v = v - $signed({2'b00, p});
        end
        f_present = pfid_pkg::WIDTH'(v);
    endfunction

    // A modulus of 0 or 1 behaves as 2.
    assign p_eff    = (r_modulus[pfid_pkg::MOD_W-1:1] == '0) ? pfid_pkg::MOD_W'(2)
                                                             : r_modulus;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != pfid_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The serial unit reduces the magnitude; a negative input maps to p - r.
    assign fix_neg = (r_state == pfid_pkg::ST_RED_OP) ? r_item.operand[pfid_pkg::WIDTH-1]
                                                      : r_item.divisor[pfid_pkg::WIDTH-1];
    assign fixed   = (fix_neg && (smod_rsp.rem != '0)) ? (p_eff - smod_rsp.rem)
                                                       : smod_rsp.rem;

    pfid_serial_mod u_smod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (smod_req),
        .i_p     (p_eff),
        .o_rsp   (smod_rsp)
    );

    pfid_euclid u_euclid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eu_req),
        .i_p     (p_eff),
        .o_rsp   (eu_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfid_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = pfid_pkg::ST_RED_OP;
                end
            end
            pfid_pkg::ST_RED_OP: begin
                if (smod_rsp.done) begin
                    case (r_item.cmd)
                        pfid_pkg::CMD_INVERSE: n_state = pfid_pkg::ST_INV;
                        pfid_pkg::CMD_DIVIDE:  n_state = pfid_pkg::ST_RED_DIV;
                        default:               n_state = pfid_pkg::ST_FIN;
                    endcase
                end
            end
            pfid_pkg::ST_RED_DIV: begin
                if (smod_rsp.done) begin
                    n_state = pfid_pkg::ST_INV;
                end
            end
            pfid_pkg::ST_INV: begin
                if (eu_rsp.done) begin
                    if (!eu_rsp.ok || (r_item.cmd == pfid_pkg::CMD_INVERSE)) begin
                        n_state = pfid_pkg::ST_FIN;
                    end else begin
                        n_state = pfid_pkg::ST_MUL;
                    end
                end
            end
            pfid_pkg::ST_MUL: begin
                n_state = pfid_pkg::ST_PROD_LOAD;
            end
            pfid_pkg::ST_PROD_LOAD: begin
                n_state = pfid_pkg::ST_RED_PROD;
            end
            pfid_pkg::ST_RED_PROD: begin
                if (smod_rsp.done) begin
                    n_state = pfid_pkg::ST_FIN;
                end
            end
            pfid_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = pfid_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfid_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        smod_req.start = 1'b0;
        smod_req.src   = pfid_pkg::SRC_W'(r_prod) << (pfid_pkg::SRC_W - pfid_pkg::PROD_W);
        smod_req.nbits = pfid_pkg::SCNT_W'(pfid_pkg::PROD_W);
        eu_req.start   = 1'b0;
        eu_req.a       = fixed;
        n_item      = r_item;
        n_a         = r_a;
        n_inv       = r_inv;
        n_prod      = r_prod;
        n_res       = r_res;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            pfid_pkg::ST_IDLE: begin
                smod_req.src   = pfid_pkg::SRC_W'(f_mag(i_in_item.operand))
                                 << (pfid_pkg::SRC_W - pfid_pkg::WIDTH);
                smod_req.nbits = pfid_pkg::SCNT_W'(pfid_pkg::WIDTH);
                if (in_acc) begin
                    smod_req.start = 1'b1;
                    n_item         = i_in_item;
                end
            end
            pfid_pkg::ST_RED_OP: begin
                smod_req.src   = pfid_pkg::SRC_W'(f_mag(r_item.divisor))
                                 << (pfid_pkg::SRC_W - pfid_pkg::WIDTH);
                smod_req.nbits = pfid_pkg::SCNT_W'(pfid_pkg::WIDTH);
                if (smod_rsp.done) begin
                    n_a      = fixed;
                    n_status = 1'b0;
                    n_res    = (r_item.cmd == pfid_pkg::CMD_REDUCE) ? fixed : '0;
                    smod_req.start = (r_item.cmd == pfid_pkg::CMD_DIVIDE);
                    eu_req.start   = (r_item.cmd == pfid_pkg::CMD_INVERSE);
                end
            end
            pfid_pkg::ST_RED_DIV: begin
                eu_req.start = smod_rsp.done;
            end
            pfid_pkg::ST_INV: begin
                if (eu_rsp.done) begin
                    n_status = !eu_rsp.ok;
                    n_res    = eu_rsp.ok ? eu_rsp.inv : '0;
                    n_inv    = eu_rsp.inv;
                end
            end
            pfid_pkg::ST_MUL: begin
                n_prod = r_a * r_inv;
            end
            pfid_pkg::ST_PROD_LOAD: begin
                smod_req.start = 1'b1;
            end
            pfid_pkg::ST_RED_PROD: begin
                if (smod_rsp.done) begin
                    n_res = smod_rsp.rem;
                end
            end
            pfid_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out.value  = f_present(r_res, p_eff, r_sym);
                    n_out.status = r_status;
                    n_out_valid  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfid_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= pfid_pkg::MODULUS_RESET;
            r_sym       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && (i_cfg_idx == pfid_pkg::CFG_MODULUS)) begin
                r_modulus <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == pfid_pkg::CFG_SYMMETRIC)) begin
                r_sym <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_a      <= n_a;
        r_inv    <= n_inv;
        r_prod   <= n_prod;
        r_res    <= n_res;
        r_status <= n_status;
        r_out    <= n_out;
    end

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status) |-> (o_out_item.value == '0))
        else $error("error transaction carries a nonzero value");

    a_status_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == pfid_pkg::ST_FIN) && r_status) |->
        ((r_item.cmd == pfid_pkg::CMD_INVERSE) || (r_item.cmd == pfid_pkg::CMD_DIVIDE)))
        else $error("inverse failure flagged for a command without inversion");

    a_eu_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eu_rsp.done |-> (r_state == pfid_pkg::ST_INV))
        else $error("Euclid unit finished outside the inversion phase");

    a_mul_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfid_pkg::ST_MUL) |-> ((r_a < p_eff) && (r_inv < p_eff)))
        else $error("multiplier operand is not a reduced residue");

endmodule
